FILE: rtl/core/mac_pkg.sv
// Shared types, codes and constants of the motor arming command controller.
// No dependencies; the front end, queue, back end and top level import this package.
`default_nettype none

package mac_pkg;

    localparam int MOTOR_COUNT_DEF = 6;
    localparam int LINE_LIMIT_DEF  = 31;
    localparam int MOTOR_MAX       = 8;
    localparam int MOTOR_IDX_W     = $clog2(MOTOR_MAX);
    localparam int OUT_MOTORS      = 6;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_W           = 16;
    localparam int THR_W           = 16;
    localparam int NUM_W           = 17;

    localparam logic [NUM_W-1:0] NUM_MAX        = '1;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET  = 16'd1000;
    localparam logic [CFG_W-1:0] THR_LOW_RESET  = 16'd1000;
    localparam logic [CFG_W-1:0] THR_HIGH_RESET = 16'd2000;
    localparam logic [THR_W-1:0] THROTTLE_RESET = 16'd1000;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [1:0] {
        REQ_BYTE   = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_BUTTON = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMED    = 2'd1,
        MODE_KILLED   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ARMED    = 3'd1,
        EV_DISARMED = 3'd2,
        EV_KILLED   = 3'd3,
        EV_TIMEOUT  = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        CFG_TIMEOUT  = 2'd0,
        CFG_THR_LOW  = 2'd1,
        CFG_THR_HIGH = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_TICK    = 3'd1,
        OP_BUTTON  = 3'd2,
        OP_ARM     = 3'd3,
        OP_DISARM  = 3'd4,
        OP_RECOVER = 3'd5,
        OP_SET_ALL = 3'd6,
        OP_SET_ONE = 3'd7
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic                   motor_ok;
        logic [MOTOR_IDX_W-1:0] motor;
        logic [NUM_W-1:0]       value;
    } t_op;

    typedef struct packed {
        logic [CFG_W-1:0] timeout;
        logic [CFG_W-1:0] thr_low;
        logic [CFG_W-1:0] thr_high;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_q_status;

    typedef struct packed {
        t_mode                             mode;
        logic                              drive_en;
        logic [OUT_MOTORS-1:0][THR_W-1:0]  throttle;
        t_event                            event_res;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/core/mac_req_if.sv
// Request channel: valid/ready handshake with request type and received byte.
// Standalone; no package dependency.
`default_nettype none

interface mac_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mac_res_if.sv
// Result channel: valid/ready handshake with mode, drive enable, six throttles
// and event code. Standalone; no package dependency.
`default_nettype none

interface mac_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        drive_enabled;
    logic [15:0] throttle_m1;
    logic [15:0] throttle_m2;
    logic [15:0] throttle_m3;
    logic [15:0] throttle_m4;
    logic [15:0] throttle_m5;
    logic [15:0] throttle_m6;
    logic [2:0]  event_res;

    modport source (
        output valid, output mode, output drive_enabled,
        output throttle_m1, output throttle_m2, output throttle_m3,
        output throttle_m4, output throttle_m5, output throttle_m6,
        output event_res, input ready
    );
    modport sink (
        input valid, input mode, input drive_enabled,
        input throttle_m1, input throttle_m2, input throttle_m3,
        input throttle_m4, input throttle_m5, input throttle_m6,
        input event_res, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/mac_front.sv
// Front end: accepts requests, parses command lines and emits classified ops.
// Depends on mac_pkg and mac_req_if.
`default_nettype none

module mac_front #(
    parameter int MOTOR_COUNT = mac_pkg::MOTOR_COUNT_DEF,
    parameter int LINE_LIMIT  = mac_pkg::LINE_LIMIT_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mac_req_if.sink           i_req,
    input  mac_pkg::t_q_status i_q_stat,
    output logic              o_push,
    output mac_pkg::t_op      o_op
);
    import mac_pkg::*;

    localparam int LP_W = $clog2(LINE_LIMIT + 1);

    logic [LP_W-1:0]  r_line_pos, n_line_pos;
    logic [7:0]       r_cmd, n_cmd;
    t_phase           r_phase, n_phase;
    logic [NUM_W-1:0] r_first, n_first;
    logic [NUM_W-1:0] r_second, n_second;
    logic             r_comma, n_comma;

    logic             w_accept;
    logic             w_byte;
    logic             w_nl;
    logic             w_take;
    logic             w_digit;
    logic [7:0]       w_diff;
    logic [NUM_W-1:0] w_first_m1;

    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [NUM_W+3:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{NUM_W{1'b0}}, d};
        return (v > {4'b0, NUM_MAX}) ? NUM_MAX : v[NUM_W-1:0];
    endfunction

    assign i_req.ready = i_q_stat.ready;
    assign w_accept    = i_req.valid & i_req.ready;
    assign o_push      = w_accept;
    assign w_byte      = (i_req.req_type == REQ_BYTE);
    assign w_nl        = (i_req.rx_byte == CH_NL);
    // a byte that lands inside the line window
    assign w_take      = w_accept & w_byte & ~w_nl & (r_line_pos < LP_W'(LINE_LIMIT));
    assign w_digit     = (i_req.rx_byte >= CH_0) && (i_req.rx_byte <= CH_9);
    assign w_diff      = i_req.rx_byte - CH_0;
    assign w_first_m1  = r_first - NUM_W'(1);

    // parse phase
    always_comb begin
        n_phase = r_phase;
        if (w_accept && w_byte && w_nl) begin
            n_phase = PH_FIRST;
        end else if (w_take && (r_line_pos != '0)) begin
            case (r_phase)
                PH_FIRST: begin
                    if (!w_digit) begin
                        n_phase = (i_req.rx_byte == CH_COMMA) ? PH_SECOND : PH_SKIP;
                    end
                end
                PH_SECOND: begin
                    if (!w_digit) begin
                        n_phase = PH_SKIP;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // line buffer fields
    always_comb begin
        n_line_pos = r_line_pos;
        n_cmd      = r_cmd;
        n_first    = r_first;
        n_second   = r_second;
        n_comma    = r_comma;
        if (w_accept && w_byte && w_nl) begin
            n_line_pos = '0;
            n_cmd      = '0;
            n_first    = '0;
            n_second   = '0;
            n_comma    = 1'b0;
        end else if (w_take) begin
            n_line_pos = r_line_pos + LP_W'(1);
            if (r_line_pos == '0) begin
                n_cmd = i_req.rx_byte;
            end else if (r_phase == PH_FIRST) begin
                if (w_digit) begin
                    n_first = add_digit(r_first, w_diff[3:0]);
                end else if (i_req.rx_byte == CH_COMMA) begin
                    n_comma = 1'b1;
                end
            end else if (r_phase == PH_SECOND && w_digit) begin
                n_second = add_digit(r_second, w_diff[3:0]);
            end
        end
    end

    // classify the accepted request
    always_comb begin
        o_op.kind     = OP_NONE;
        o_op.motor_ok = (r_first >= NUM_W'(1)) && (r_first <= NUM_W'(MOTOR_COUNT));
        o_op.motor    = w_first_m1[MOTOR_IDX_W-1:0];
        o_op.value    = r_comma ? r_second : r_first;
        case (t_req'(i_req.req_type))
            REQ_BYTE: begin
                if (w_nl && (r_line_pos != '0)) begin
                    case (r_cmd)
                        CH_A:    o_op.kind = OP_ARM;
                        CH_D:    o_op.kind = OP_DISARM;
                        CH_R:    o_op.kind = OP_RECOVER;
                        CH_S:    o_op.kind = r_comma ? OP_SET_ONE : OP_SET_ALL;
                        default: o_op.kind = OP_NONE;
                    endcase
                end
            end
            REQ_TICK:   o_op.kind = OP_TICK;
            REQ_BUTTON: o_op.kind = OP_BUTTON;
            default:    o_op.kind = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos <= '0;
            r_cmd      <= '0;
            r_phase    <= PH_FIRST;
            r_first    <= '0;
            r_second   <= '0;
            r_comma    <= 1'b0;
        end else begin
            r_line_pos <= n_line_pos;
            r_cmd      <= n_cmd;
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_second   <= n_second;
            r_comma    <= n_comma;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mac_queue.sv
// Short op queue between the parser front end and the execution back end.
// Depends on mac_pkg.
`default_nettype none

module mac_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  mac_pkg::t_op       i_op,
    input  wire                i_pop,
    output mac_pkg::t_q_status o_stat,
    output mac_pkg::t_op       o_op
);
    import mac_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_stat.valid = (r_count != '0);
    assign o_stat.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_op         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mac_back.sv
// Back end: arm/disarm/kill state, throttle store, watchdog and result register.
// Depends on mac_pkg and mac_res_if.
`default_nettype none

module mac_back #(
    parameter int MOTOR_COUNT = mac_pkg::MOTOR_COUNT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mac_pkg::t_cfg       i_cfg,
    input  mac_pkg::t_q_status  i_q_stat,
    input  mac_pkg::t_op        i_op,
    output logic                o_pop,
    mac_res_if.source           o_res
);
    import mac_pkg::*;

    t_mode            r_mode, n_mode;
    logic             r_on, n_on;
    logic [THR_W-1:0] r_store [MOTOR_COUNT];
    logic [THR_W-1:0] n_store [MOTOR_COUNT];
    logic [NUM_W-1:0] r_idle, n_idle;
    t_event           w_ev;
    logic [THR_W-1:0] w_idle_thr;
    logic [THR_W-1:0] w_set_thr;
    logic [OUT_MOTORS-1:0][THR_W-1:0] w_thr;

    t_res             r_out;
    logic             r_out_valid;

    // raise to low first, then cap at high: high wins when the limits cross
    function automatic logic [THR_W-1:0] clamp(input logic [NUM_W-1:0] v,
                                               input logic [CFG_W-1:0] lo,
                                               input logic [CFG_W-1:0] hi);
        logic [NUM_W-1:0] t;
        t = (v < {1'b0, lo}) ? {1'b0, lo} : v;
        return (t > {1'b0, hi}) ? hi : t[THR_W-1:0];
    endfunction

    assign o_pop      = i_q_stat.valid & (~r_out_valid | o_res.ready);
    assign w_idle_thr = clamp({1'b0, i_cfg.thr_low}, i_cfg.thr_low, i_cfg.thr_high);
    assign w_set_thr  = clamp(i_op.value, i_cfg.thr_low, i_cfg.thr_high);

    always_comb begin
        n_mode  = r_mode;
        n_on    = r_on;
        n_store = r_store;
        n_idle  = r_idle;
        w_ev    = EV_NONE;
        if (o_pop) begin
            case (i_op.kind)
                OP_TICK: begin
                    if (r_idle != NUM_MAX) begin
                        n_idle = r_idle + NUM_W'(1);
                    end
                end
                OP_BUTTON: begin
                    if (r_mode == MODE_KILLED) begin
                        n_mode = MODE_DISARMED;
                        n_on   = 1'b1;
                        w_ev   = EV_DISARMED;
                    end else begin
                        n_mode = MODE_KILLED;
                        n_on   = 1'b0;
                        w_ev   = EV_KILLED;
                    end
                end
                OP_ARM: begin
                    if (r_mode != MODE_KILLED) begin
                        n_mode = MODE_ARMED;
                        n_idle = '0;
                        for (int k = 0; k < MOTOR_COUNT; k++) begin
                            n_store[k] = w_idle_thr;
                        end
                        w_ev = EV_ARMED;
                    end
                end
                OP_DISARM: begin
                    n_mode = MODE_DISARMED;
                    for (int k = 0; k < MOTOR_COUNT; k++) begin
                        n_store[k] = w_idle_thr;
                    end
                    w_ev = EV_DISARMED;
                end
                OP_RECOVER: begin
                    if (r_mode == MODE_KILLED) begin
                        n_mode = MODE_DISARMED;
                        n_on   = 1'b1;
                        w_ev   = EV_DISARMED;
                    end
                end
                OP_SET_ALL: begin
                    if (r_mode == MODE_ARMED) begin
                        for (int k = 0; k < MOTOR_COUNT; k++) begin
                            n_store[k] = w_set_thr;
                        end
                        n_idle = '0;
                    end
                end
                OP_SET_ONE: begin
                    if (r_mode == MODE_ARMED) begin
                        for (int k = 0; k < MOTOR_COUNT; k++) begin
                            if (i_op.motor_ok && (i_op.motor == MOTOR_IDX_W'(k))) begin
                                n_store[k] = w_set_thr;
                            end
                        end
                        n_idle = '0;
                    end
                end
                default: n_idle = r_idle;
            endcase

            // watchdog: drop an armed block that has gone quiet too long
            if ((n_mode == MODE_ARMED) && (n_idle > {1'b0, i_cfg.timeout})) begin
                n_mode = MODE_DISARMED;
                for (int k = 0; k < MOTOR_COUNT; k++) begin
                    n_store[k] = w_idle_thr;
                end
                w_ev = EV_TIMEOUT;
            end
        end
    end

    for (genvar g = 0; g < OUT_MOTORS; g++) begin : g_thr
        if (g < MOTOR_COUNT) begin : g_used
            assign w_thr[g] = n_store[g];
        end else begin : g_unused
            assign w_thr[g] = THROTTLE_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DISARMED;
            r_on        <= 1'b1;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_store[k] <= THROTTLE_RESET;
            end
        end else begin
            r_mode  <= n_mode;
            r_on    <= n_on;
            r_idle  <= n_idle;
            r_store <= n_store;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.mode      <= n_mode;
            r_out.drive_en  <= n_on;
            r_out.throttle  <= w_thr;
            r_out.event_res <= w_ev;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.mode          = r_out.mode;
    assign o_res.drive_enabled = r_out.drive_en;
    assign o_res.throttle_m1   = r_out.throttle[0];
    assign o_res.throttle_m2   = r_out.throttle[1];
    assign o_res.throttle_m3   = r_out.throttle[2];
    assign o_res.throttle_m4   = r_out.throttle[3];
    assign o_res.throttle_m5   = r_out.throttle[4];
    assign o_res.throttle_m6   = r_out.throttle[5];
    assign o_res.event_res     = r_out.event_res;

endmodule

`default_nettype wire

FILE: rtl/core/motor_arming_command_controller.sv
// Motor arming command controller: top level with configuration registers.
// Depends on mac_pkg, mac_req_if, mac_res_if, mac_front, mac_queue, mac_back.
//
// Usage:
//   i_req carries one transaction per received UART byte (req_type 0), per
//   millisecond tick (req_type 1) or per kill button press (req_type 2).
//   Every accepted transaction yields exactly one transaction on o_res with
//   the mode, drive enable, six throttle compare values and an event code.
//   A newline byte runs the buffered command line (A, D, R, S<v>, S<m>,<v>).
//   The config port (i_cfg_we/i_cfg_idx/i_cfg_data) sets timeout_ticks,
//   throttle_low and throttle_high; write it only while the block is idle.
// Timing:
//   Result valid rises once an accepted op has passed the op queue and the
//   result register. Throughput is one transaction per cycle while o_res
//   is not stalled and the op queue is not full.
// Reset and stall:
//   Synchronous active-low reset clears the line buffer, disarms, enables
//   the drive, sets all throttles to 1000 and loads the register defaults.
//   When the receiver stalls o_res, the result register holds, the 2-entry
//   op queue fills, and i_req.ready drops once the queue is full.
`default_nettype none

module motor_arming_command_controller #(
    parameter int MOTOR_COUNT = mac_pkg::MOTOR_COUNT_DEF,
    parameter int LINE_LIMIT  = mac_pkg::LINE_LIMIT_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    mac_req_if.sink                  i_req,
    mac_res_if.source                o_res,
    input  wire                      i_cfg_we,
    input  wire [1:0]                i_cfg_idx,
    input  wire [mac_pkg::CFG_W-1:0] i_cfg_data
);
    import mac_pkg::*;

    t_cfg      r_cfg;
    t_q_status w_q_stat;
    t_op       w_push_op;
    t_op       w_pop_op;
    logic      w_push;
    logic      w_pop;

    // Configuration registers: take the write, drop unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout  <= TIMEOUT_RESET;
            r_cfg.thr_low  <= THR_LOW_RESET;
            r_cfg.thr_high <= THR_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TIMEOUT:  r_cfg.timeout  <= i_cfg_data;
                CFG_THR_LOW:  r_cfg.thr_low  <= i_cfg_data;
                CFG_THR_HIGH: r_cfg.thr_high <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Front end: parse bytes and classify every transaction into an op.
    mac_front #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .LINE_LIMIT  (LINE_LIMIT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_op     (w_push_op)
    );

    // Decouple the parser from the executor so either side can stall alone.
    mac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_op    (w_pop_op)
    );

    // Back end: advance the arming state and register the result.
    mac_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .i_op     (w_pop_op),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

`ifndef NO_ASSERTIONS
    // A killed block never drives the motors.
    a_killed_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.mode == MODE_KILLED)) |-> !o_res.drive_enabled)
        else $error("killed mode reported with drive enabled");

    // Reset empties the result register.
    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    // An op pushed without a pop leaves the queue non-empty.
    a_queue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> w_q_stat.valid)
        else $error("queue lost a pushed op");

    // Arm and timeout events agree with the reported mode.
    a_event_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && ((o_res.event_res == EV_ARMED) ||
                         (o_res.event_res == EV_TIMEOUT)))
        |-> (o_res.mode == ((o_res.event_res == EV_ARMED) ? MODE_ARMED : MODE_DISARMED)))
        else $error("event code disagrees with mode");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_motor_arming_command_controller.sv
// Self-checking testbench for motor_arming_command_controller: feeds command
// bytes, ticks and kill button presses, predicts every result and checks it.
// Depends on mac_pkg, mac_req_if, mac_res_if and the block's RTL.
`timescale 1ns / 100ps

module tb_motor_arming_command_controller;
    import mac_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int REPORT_MAX   = 10;
    localparam int SEG_COUNT    = 6;
    localparam int SEG_ITEMS    = 100;

    // request code the block has no use for; it must only see the timeout check
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // register settings per random segment: timeout, throttle low, throttle high
    localparam logic [CFG_W-1:0] SEG_TIMEOUT [SEG_COUNT] = '{20, 1, 65535, 8, 50, 3};
    localparam logic [CFG_W-1:0] SEG_LOW     [SEG_COUNT] = '{0, 65535, 1500, 500, 1000, 900};
    localparam logic [CFG_W-1:0] SEG_HIGH    [SEG_COUNT] = '{65535, 65535, 1200, 0, 2000, 1900};

    typedef struct packed {
        t_mode                            mode;
        logic                             drive_en;
        logic [OUT_MOTORS-1:0][THR_W-1:0] thr;   // thr[0] is motor one
        t_event                           ev;
    } t_arm_status;

    // Tracks the arming state machine and the line parser, and keeps the
    // status every accepted transaction must produce, oldest first.
    class ArmingScoreboard;
        logic [CFG_W-1:0] timeout_ticks;
        logic [CFG_W-1:0] thr_low;
        logic [CFG_W-1:0] thr_high;
        int unsigned      line_pos;
        logic [7:0]       cmd_char;
        t_phase           phase;
        logic [NUM_W-1:0] first_num;
        logic [NUM_W-1:0] second_num;
        bit               comma_seen;
        t_mode            mode;
        bit               drive_on;
        logic [THR_W-1:0] thr [OUT_MOTORS];
        logic [NUM_W-1:0] idle_ticks;
        t_arm_status      status_q [$];
        int unsigned      mismatches;
        int unsigned      checked;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            thr_low       = THR_LOW_RESET;
            thr_high      = THR_HIGH_RESET;
            clear_line();
            mode       = MODE_DISARMED;
            drive_on   = 1'b1;
            foreach (thr[i]) thr[i] = THROTTLE_RESET;
            idle_ticks = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void clear_line();
            line_pos   = 0;
            cmd_char   = 8'h00;
            phase      = PH_FIRST;
            first_num  = '0;
            second_num = '0;
            comma_seen = 1'b0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_TIMEOUT:  timeout_ticks = data;
                CFG_THR_LOW:  thr_low = data;
                CFG_THR_HIGH: thr_high = data;
                default: ;
            endcase
        endfunction

        // low bound first, then high bound: high wins when the two cross
        function logic [THR_W-1:0] clamp(logic [NUM_W-1:0] v);
            logic [NUM_W-1:0] r;
            r = v;
            if (r < {1'b0, thr_low}) r = {1'b0, thr_low};
            if (r > {1'b0, thr_high}) r = {1'b0, thr_high};
            return r[THR_W-1:0];
        endfunction

        function void set_all(logic [NUM_W-1:0] v);
            foreach (thr[i]) thr[i] = clamp(v);
        endfunction

        function logic [NUM_W-1:0] add_digit(logic [NUM_W-1:0] acc, logic [7:0] ch);
            int unsigned v;
            v = 32'(acc) * 10 + 32'(ch) - 32'(CH_0);
            return (v > 32'(NUM_MAX)) ? NUM_MAX : v[NUM_W-1:0];
        endfunction

        function t_event run_line();
            t_event ev;
            ev = EV_NONE;
            if (line_pos == 0) return ev;
            case (cmd_char)
                CH_A: if (mode != MODE_KILLED) begin
                    mode       = MODE_ARMED;
                    idle_ticks = '0;
                    set_all({1'b0, thr_low});
                    ev = EV_ARMED;
                end
                CH_D: begin
                    mode = MODE_DISARMED;
                    set_all({1'b0, thr_low});
                    ev = EV_DISARMED;
                end
                CH_R: if (mode == MODE_KILLED) begin
                    drive_on = 1'b1;
                    mode     = MODE_DISARMED;
                    ev       = EV_DISARMED;
                end
                CH_S: if (mode == MODE_ARMED) begin
                    if (!comma_seen) begin
                        set_all(first_num);
                    end else if (first_num >= 1 && first_num <= MOTOR_COUNT_DEF) begin
                        thr[first_num - 1] = clamp(second_num);
                    end
                    idle_ticks = '0;
                end
                default: ;
            endcase
            return ev;
        endfunction

        function void take_byte(logic [7:0] b);
            bit digit;
            digit = (b >= CH_0 && b <= CH_9);
            if (line_pos >= LINE_LIMIT_DEF) return;
            if (line_pos == 0) begin
                cmd_char = b;
            end else if (phase == PH_FIRST) begin
                if (digit) first_num = add_digit(first_num, b);
                else if (b == CH_COMMA) begin
                    comma_seen = 1'b1;
                    phase      = PH_SECOND;
                end else phase = PH_SKIP;
            end else if (phase == PH_SECOND) begin
                if (digit) second_num = add_digit(second_num, b);
                else phase = PH_SKIP;
            end
            line_pos++;
        endfunction

        function void note_request(logic [1:0] rt, logic [7:0] b);
            t_event      ev;
            t_arm_status st;
            ev = EV_NONE;
            case (rt)
                REQ_BYTE: begin
                    if (b == CH_NL) begin
                        ev = run_line();
                        clear_line();
                    end else begin
                        take_byte(b);
                    end
                end
                REQ_TICK: if (idle_ticks != NUM_MAX) idle_ticks++;
                REQ_BUTTON: begin
                    if (mode == MODE_KILLED) begin
                        drive_on = 1'b1;
                        mode     = MODE_DISARMED;
                        ev       = EV_DISARMED;
                    end else begin
                        drive_on = 1'b0;
                        mode     = MODE_KILLED;
                        ev       = EV_KILLED;
                    end
                end
                default: ;
            endcase
            if (mode == MODE_ARMED && idle_ticks > {1'b0, timeout_ticks}) begin
                mode = MODE_DISARMED;
                set_all({1'b0, thr_low});
                ev = EV_TIMEOUT;
            end
            st.mode     = mode;
            st.drive_en = drive_on;
            for (int i = 0; i < OUT_MOTORS; i++) st.thr[i] = thr[i];
            st.ev       = ev;
            status_q.push_back(st);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d, %s: expected %0d, got %0d", checked, name, want, got);
            end
        endfunction

        function void check_result(t_arm_status got);
            t_arm_status want;
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d arrived with no transaction pending", checked);
                return;
            end
            want = status_q.pop_front();
            compare_field("mode", want.mode, got.mode);
            compare_field("drive_enabled", want.drive_en, got.drive_en);
            for (int i = 0; i < OUT_MOTORS; i++)
                compare_field($sformatf("throttle_m%0d", i + 1), want.thr[i], got.thr[i]);
            compare_field("event_res", want.ev, got.ev);
            checked++;
        endfunction

        function int unsigned pending();
            return status_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned cycle_count    = 0;
    int unsigned accepted_items = 0;

    ArmingScoreboard arm_sb = new();

    mac_req_if req_ch ();
    mac_res_if res_ch ();

    motor_arming_command_controller dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Abort a run that hangs; a correct run ends far below this.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check every transaction taken at this edge against the
    // oldest prediction, then pick ready for the next edge. Stall at random
    // according to the current receiver idle rate.
    initial begin
        t_arm_status got;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) begin
                got.mode     = t_mode'(res_ch.mode);
                got.drive_en = res_ch.drive_enabled;
                got.thr[0]   = res_ch.throttle_m1;
                got.thr[1]   = res_ch.throttle_m2;
                got.thr[2]   = res_ch.throttle_m3;
                got.thr[3]   = res_ch.throttle_m4;
                got.thr[4]   = res_ch.throttle_m5;
                got.thr[5]   = res_ch.throttle_m6;
                got.ev       = t_event'(res_ch.event_res);
                arm_sb.check_result(got);
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request transaction and hold it until the block takes it.
    // Valid stays high on return so back-to-back transactions need no gap;
    // idle cycles before the offer drop it.
    task automatic push_request(logic [1:0] rt, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.rx_byte  <= b;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        arm_sb.note_request(rt, b);
        accepted_items++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) push_request(REQ_BYTE, s[i]);
    endtask

    // Write all three registers back to back; call only while the block is idle.
    task automatic write_registers(logic [CFG_W-1:0] timeout, logic [CFG_W-1:0] low,
                                   logic [CFG_W-1:0] high);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TIMEOUT;
        cfg_data <= timeout;
        arm_sb.set_register(CFG_TIMEOUT, timeout);
        @(posedge clk);
        cfg_idx  <= CFG_THR_LOW;
        cfg_data <= low;
        arm_sb.set_register(CFG_THR_LOW, low);
        @(posedge clk);
        cfg_idx  <= CFG_THR_HIGH;
        cfg_data <= high;
        arm_sb.set_register(CFG_THR_HIGH, high);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid, then wait for every predicted result and let the pipeline
    // settle so the block is truly quiet.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (arm_sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Throttle value text: empty, plain 16-bit, long digit runs that saturate
    // the accumulator, or values at or one off the clamp bounds.
    function automatic string number_text();
        string s;
        s = "";
        case ($urandom_range(3))
            0: ;
            1: s = $sformatf("%0d", $urandom_range(65535));
            2: repeat ($urandom_range(7, 1)) s = $sformatf("%s%0d", s, $urandom_range(9));
            default: begin
                if ($urandom_range(1) != 0)
                    s = $sformatf("%0d", int'(arm_sb.thr_low) + $urandom_range(2) - 1);
                else
                    s = $sformatf("%0d", int'(arm_sb.thr_high) + $urandom_range(2) - 1);
            end
        endcase
        return s;
    endfunction

    // A command line: mostly S commands, some A, D and R, rarely one random character.
    function automatic string command_line();
        int unsigned pick;
        string       s;
        pick = $urandom_range(99);
        if (pick < 20) s = "A";
        else if (pick < 28) s = "D";
        else if (pick < 35) s = "R";
        else if (pick < 95) begin
            s = "S";
            if ($urandom_range(2) != 0)
                s = $sformatf("%s%0d,", s, ($urandom_range(7) != 0) ? $urandom_range(6, 1)
                                                                     : $urandom_range(12));
            s = {s, number_text()};
        end else s = $sformatf("%c", $urandom_range(126, 33));
        return {s, "\n"};
    endfunction

    // Put a value digit on either side of the line length limit.
    function automatic string long_line();
        string s;
        s = $sformatf("S%0d,", $urandom_range(6, 1));
        repeat ($urandom_range(34, 20)) s = {s, "0"};
        return $sformatf("%s%0d\n", s, $urandom_range(9, 1));
    endfunction

    // S followed by a jumble of digits, commas and junk.
    function automatic string broken_line();
        string s;
        s = "S";
        repeat ($urandom_range(8, 1)) begin
            case ($urandom_range(3))
                0: s = {s, ","};
                1: s = {s, "x"};
                2: s = {s, " "};
                default: s = $sformatf("%s%0d", s, $urandom_range(9));
            endcase
        end
        return {s, "\n"};
    endfunction

    task automatic random_traffic(int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = accepted_items + count;
        while (accepted_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_text(command_line());
            end else if (pick < 68) begin
                // long tick bursts can push an armed block past its timeout
                repeat (($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(6, 1))
                    push_request(REQ_TICK, 8'($urandom));
            end else if (pick < 74) begin
                push_request(REQ_BUTTON, 8'($urandom));
            end else if (pick < 82) begin
                send_text(long_line());
            end else if (pick < 92) begin
                repeat ($urandom_range(4, 1)) push_request(2'($urandom), 8'($urandom));
            end else begin
                send_text(broken_line());
            end
        end
    endtask

    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_BYTE;
        req_ch.rx_byte  <= 8'h00;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_TIMEOUT;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset register values.
        send_idle_pct = 27;
        recv_idle_pct = 83;
        send_text("\n");                    // empty line does nothing
        push_request(REQ_BUTTON, 8'h00);    // kill
        send_text("A\n");                   // arm refused while killed
        send_text("D\n");                   // disarm while killed, drive stays off
        push_request(REQ_BUTTON, 8'hFF);    // kill again
        send_text("R\n");                   // recover
        send_text("R\n");                   // recover when not killed is ignored
        send_text("S5\n");                  // set refused while disarmed
        send_text("A\n");
        send_text("S9,1\n");                // motor index out of range
        send_text("S6,65535\n");            // clamp to the high bound
        send_text("S0\n");                  // clamp all to the low bound
        push_request(REQ_TICK, 8'hA5);
        push_request(REQ_UNUSED, 8'h5A);
        send_text("Q\n");                   // unknown letter
        drain();

        // Random segments; each pair shares one idle pattern: sender light and
        // receiver heavy, then swapped, then no idling at all.
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg < 2) begin
                send_idle_pct = 27;
                recv_idle_pct = 83;
            end else if (seg < 4) begin
                send_idle_pct = 83;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_registers(SEG_TIMEOUT[seg], SEG_LOW[seg], SEG_HIGH[seg]);
            random_traffic(SEG_ITEMS);
            drain();
        end

        if (arm_sb.mismatches == 0 && arm_sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
